// ===== design/skf_pkg.sv =====
// Package for the servo keyframe interpolator: widths, payload types,
// constant-reciprocal division helpers and the pulse-width conversion.
// No dependencies.
package skf_pkg;

    localparam int SERVO_COUNT   = 8;
    localparam int SUBSTEPS      = 5;
    localparam int ANGLE_MAX     = 180;
    localparam int PULSE_MIN_NS  = 500000;
    localparam int PULSE_SPAN_NS = 2000000;

    localparam int ANGLE_W = 8;
    localparam int DELTA_W = 9;
    localparam int PULSE_W = 22;
    localparam int DUR_W   = 16;
    localparam int DWELL_W = 14;
    localparam int DWELL_MAX = 2 ** DWELL_W - 1;
    localparam int STEP_W  = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;
    localparam int NUM_W   = $clog2(ANGLE_MAX * SUBSTEPS + 1);

    // num / SUBSTEPS by reciprocal multiply, exact over NUM_W bits
    localparam int DIV_SH = NUM_W + $clog2(SUBSTEPS);
    localparam int DIV_M  = (2 ** DIV_SH + SUBSTEPS - 1) / SUBSTEPS;
    localparam int DIV_MW = $clog2(DIV_M + 1);

    // dur / SUBSTEPS, exact over DUR_W bits
    localparam int DUR_SH = DUR_W + $clog2(SUBSTEPS);
    localparam int DUR_M  = (2 ** DUR_SH + SUBSTEPS - 1) / SUBSTEPS;
    localparam int DUR_MW = $clog2(DUR_M + 1);

    // pos * SPAN / ANGLE_MAX = pos * PULSE_Q + (pos * PULSE_R) / ANGLE_MAX
    localparam int PULSE_Q = PULSE_SPAN_NS / ANGLE_MAX;
    localparam int PULSE_R = PULSE_SPAN_NS % ANGLE_MAX;
    localparam int FRAC_W  = $clog2(ANGLE_MAX * PULSE_R + 1) + 1;
    localparam int FRAC_SH = FRAC_W + $clog2(ANGLE_MAX);
    localparam int FRAC_M  = (2 ** FRAC_SH + ANGLE_MAX - 1) / ANGLE_MAX;
    localparam int FRAC_MW = $clog2(FRAC_M + 1);

    typedef logic [ANGLE_W-1:0]        t_angle;
    typedef logic signed [DELTA_W-1:0] t_delta;
    typedef logic [NUM_W-1:0]          t_num;
    typedef logic [STEP_W-1:0]         t_step;
    typedef logic [PULSE_W-1:0]        t_pulse;
    typedef logic [DUR_W-1:0]          t_dur;
    typedef logic [DWELL_W-1:0]        t_dwell;

    typedef struct packed {
        logic                       valid;
        logic                       last;
        t_dwell                     dwell;
        t_num [SERVO_COUNT-1:0]     num;
    } t_sub;

    function automatic t_angle div_steps(input t_num n);
        logic [NUM_W+DIV_MW-1:0] p;
        p = (NUM_W + DIV_MW)'(n) * (NUM_W + DIV_MW)'(DIV_M);
        return ANGLE_W'(p >> DIV_SH);
    endfunction

    function automatic t_dwell dwell_of(input t_dur d);
        logic [DUR_W+DUR_MW-1:0] p;
        logic [DUR_W-1:0]        q;
        p = (DUR_W + DUR_MW)'(d) * (DUR_W + DUR_MW)'(DUR_M);
        q = DUR_W'(p >> DUR_SH);
        if (q > DUR_W'(DWELL_MAX)) begin
            return DWELL_W'(DWELL_MAX);
        end
        return DWELL_W'(q);
    endfunction

    function automatic t_pulse pulse_of(input t_angle pos);
        logic [FRAC_W-1:0]         fr;
        logic [FRAC_W+FRAC_MW-1:0] p;
        logic [PULSE_W-1:0]        base;
        fr   = FRAC_W'(pos) * FRAC_W'(PULSE_R);
        p    = (FRAC_W + FRAC_MW)'(fr) * (FRAC_W + FRAC_MW)'(FRAC_M);
        base = PULSE_W'(pos) * PULSE_W'(PULSE_Q);
        return PULSE_W'(PULSE_MIN_NS) + base + PULSE_W'(p >> FRAC_SH);
    endfunction

endpackage

// ===== design/skf_if.sv =====
// Handshake channels of the servo keyframe interpolator: keyframe rows in,
// subframes out. Depends on skf_pkg.
interface skf_row_if;
    import skf_pkg::*;
    logic   valid;
    logic   ready;
    logic   first_row;
    t_delta angle_1;
    t_delta angle_2;
    t_delta angle_3;
    t_delta angle_4;
    t_delta angle_5;
    t_delta angle_6;
    t_delta angle_7;
    t_delta angle_8;
    t_dur   row_duration_ms;
    modport source (output valid, first_row, angle_1, angle_2, angle_3, angle_4,
                    angle_5, angle_6, angle_7, angle_8, row_duration_ms,
                    input ready);
    modport sink   (input valid, first_row, angle_1, angle_2, angle_3, angle_4,
                    angle_5, angle_6, angle_7, angle_8, row_duration_ms,
                    output ready);
endinterface

interface skf_frame_if;
    import skf_pkg::*;
    logic   valid;
    logic   ready;
    t_pulse pulse_1;
    t_pulse pulse_2;
    t_pulse pulse_3;
    t_pulse pulse_4;
    t_pulse pulse_5;
    t_pulse pulse_6;
    t_pulse pulse_7;
    t_pulse pulse_8;
    t_dwell dwell_ms;
    logic   last_subframe;
    modport source (output valid, pulse_1, pulse_2, pulse_3, pulse_4, pulse_5,
                    pulse_6, pulse_7, pulse_8, dwell_ms, last_subframe,
                    input ready);
    modport sink   (input valid, pulse_1, pulse_2, pulse_3, pulse_4, pulse_5,
                    pulse_6, pulse_7, pulse_8, dwell_ms, last_subframe,
                    output ready);
endinterface

// ===== design/servo_keyframe_interpolator_core.sv =====
// Servo keyframe interpolator top level: row stage feeding subframe stage.
// Depends on skf_pkg, skf_if, skf_row_stage, skf_subframe_stage.
//
//   channel   dir  handshake    carries
//   i_row     in   valid/ready  first_row, angle_1..8, row_duration_ms
//   o_frame   out  valid/ready  pulse_1..8, dwell_ms, last_subframe
//
// One row yields five subframe transactions, one per cycle while o_frame is
// taken; the row register's subframe counter steps through the five subframes.
// A new row is taken in the cycle its predecessor's last subframe moves from the row register to the output register.
// A row's first subframe passes through the row register and then the output register.
// Synchronous reset clears the stored targets to zero and empties both stages.
// A stall on o_frame holds the output register and the row register.
module servo_keyframe_interpolator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    skf_row_if.sink     i_row,
    skf_frame_if.source o_frame
);
    import skf_pkg::*;

    t_delta [SERVO_COUNT-1:0] w_angle;
    t_pulse [SERVO_COUNT-1:0] w_pulse;
    t_sub                     w_sub;
    logic                     w_advance;

    assign w_angle[0] = i_row.angle_1;
    assign w_angle[1] = i_row.angle_2;
    assign w_angle[2] = i_row.angle_3;
    assign w_angle[3] = i_row.angle_4;
    assign w_angle[4] = i_row.angle_5;
    assign w_angle[5] = i_row.angle_6;
    assign w_angle[6] = i_row.angle_7;
    assign w_angle[7] = i_row.angle_8;

    skf_row_stage u_row (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_row.valid),
        .o_ready    (i_row.ready),
        .i_first    (i_row.first_row),
        .i_angle    (w_angle),
        .i_duration (i_row.row_duration_ms),
        .i_advance  (w_advance),
        .o_sub      (w_sub)
    );

    skf_subframe_stage u_sub (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sub     (w_sub),
        .o_advance (w_advance),
        .o_valid   (o_frame.valid),
        .i_ready   (o_frame.ready),
        .o_pulse   (w_pulse),
        .o_dwell   (o_frame.dwell_ms),
        .o_last    (o_frame.last_subframe)
    );

    assign o_frame.pulse_1 = w_pulse[0];
    assign o_frame.pulse_2 = w_pulse[1];
    assign o_frame.pulse_3 = w_pulse[2];
    assign o_frame.pulse_4 = w_pulse[3];
    assign o_frame.pulse_5 = w_pulse[4];
    assign o_frame.pulse_6 = w_pulse[5];
    assign o_frame.pulse_7 = w_pulse[6];
    assign o_frame.pulse_8 = w_pulse[7];

endmodule

// ===== design/skf_row_stage.sv =====
// Row register: target angle state, start/target resolution and the
// per-subframe numerator accumulators. Depends on skf_pkg.
module skf_row_stage (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic                                        i_first,
    input  skf_pkg::t_delta [skf_pkg::SERVO_COUNT-1:0]  i_angle,
    input  skf_pkg::t_dur                               i_duration,
    input  logic                                        i_advance,
    output skf_pkg::t_sub                               o_sub
);
    import skf_pkg::*;

    t_angle r_target [SERVO_COUNT];
    t_num   r_num    [SERVO_COUNT];
    t_delta r_delta  [SERVO_COUNT];
    t_dwell r_dwell;
    t_step  r_step;
    logic   r_valid;

    t_angle               n_target [SERVO_COUNT];
    t_num                 n_num    [SERVO_COUNT];
    t_delta               n_delta  [SERVO_COUNT];
    logic signed [DELTA_W:0] w_sum [SERVO_COUNT];
    t_angle               w_start  [SERVO_COUNT];
    logic                 w_last;
    logic                 w_accept;

    assign w_last   = (r_step == STEP_W'(SUBSTEPS - 1));
    assign o_ready  = !r_valid || (i_advance && w_last);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        for (int s = 0; s < SERVO_COUNT; s++) begin
            if (i_first) begin
                w_sum[s] = (DELTA_W + 1)'($signed(i_angle[s]));
            end else begin
                w_sum[s] = $signed({2'b00, r_target[s]}) +
                           (DELTA_W + 1)'($signed(i_angle[s]));
            end
            if (w_sum[s] < 0) begin
                n_target[s] = '0;
            end else if (w_sum[s] > $signed((DELTA_W + 1)'(ANGLE_MAX))) begin
                n_target[s] = ANGLE_W'(ANGLE_MAX);
            end else begin
                n_target[s] = w_sum[s][ANGLE_W-1:0];
            end
            w_start[s] = i_first ? n_target[s] : r_target[s];
            n_delta[s] = $signed({1'b0, n_target[s]}) - $signed({1'b0, w_start[s]});
            n_num[s]   = NUM_W'(w_start[s]) * NUM_W'(SUBSTEPS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
            for (int s = 0; s < SERVO_COUNT; s++) begin
                r_target[s] <= '0;
            end
        end else if (w_accept) begin
            r_valid <= 1'b1;
            r_step  <= '0;
            r_dwell <= dwell_of(i_duration);
            for (int s = 0; s < SERVO_COUNT; s++) begin
                r_target[s] <= n_target[s];
                r_num[s]    <= n_num[s];
                r_delta[s]  <= n_delta[s];
            end
        end else if (r_valid && i_advance) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end else begin
                r_step <= r_step + 1'b1;
                for (int s = 0; s < SERVO_COUNT; s++) begin
                    r_num[s] <= r_num[s] + NUM_W'(r_delta[s]);
                end
            end
        end
    end

    always_comb begin
        o_sub.valid = r_valid;
        o_sub.last  = w_last;
        o_sub.dwell = r_dwell;
        for (int s = 0; s < SERVO_COUNT; s++) begin
            o_sub.num[s] = r_num[s];
        end
    end

endmodule

// ===== design/skf_subframe_stage.sv =====
// Subframe output register: position and pulse-width conversion per servo.
// Depends on skf_pkg.
module skf_subframe_stage (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  skf_pkg::t_sub                               i_sub,
    output logic                                        o_advance,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output skf_pkg::t_pulse [skf_pkg::SERVO_COUNT-1:0]  o_pulse,
    output skf_pkg::t_dwell                             o_dwell,
    output logic                                        o_last
);
    import skf_pkg::*;

    logic                    r_valid;
    t_pulse [SERVO_COUNT-1:0] r_pulse;
    t_dwell                  r_dwell;
    logic                    r_last;
    t_pulse [SERVO_COUNT-1:0] n_pulse;
    logic                    w_free;

    assign w_free    = !r_valid || i_ready;
    assign o_advance = w_free;

    always_comb begin
        for (int s = 0; s < SERVO_COUNT; s++) begin
            n_pulse[s] = pulse_of(div_steps(i_sub.num[s]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_free) begin
            r_valid <= i_sub.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free && i_sub.valid) begin
            r_pulse <= n_pulse;
            r_dwell <= i_sub.dwell;
            r_last  <= i_sub.last;
        end
    end

    assign o_valid = r_valid;
    assign o_pulse = r_pulse;
    assign o_dwell = r_dwell;
    assign o_last  = r_last;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for servo_keyframe_interpolator_core: drives keyframe rows, predicts
// the five subframes of each row and checks every subframe transaction.
// Depends on skf_pkg, skf_if and the core RTL.

import skf_pkg::*;

typedef struct packed {
    logic                     first;
    t_delta [SERVO_COUNT-1:0] ang;
    t_dur                     dur;
} t_row_item;

typedef struct packed {
    t_pulse [SERVO_COUNT-1:0] pulse;
    t_dwell                   dwell;
    logic                     last;
} t_subframe;

class subframe_scoreboard;
    t_angle    held_target [SERVO_COUNT];
    t_subframe due_q [$];
    int        mismatches;

    function new();
        foreach (held_target[s]) begin
            held_target[s] = '0;
        end
        mismatches = 0;
    endfunction

    function int limit_deg(input int v);
        if (v < 0) begin
            return 0;
        end
        if (v > ANGLE_MAX) begin
            return ANGLE_MAX;
        end
        return v;
    endfunction

    function int pending();
        return due_q.size();
    endfunction

    // Predict the subframes of an accepted row and update the held targets.
    function void note_row(input t_row_item r);
        int        start_deg [SERVO_COUNT];
        int        goal_deg [SERVO_COUNT];
        int        delta;
        int        pos;
        int        q;
        t_subframe sf;
        q = int'(r.dur) / SUBSTEPS;
        if (q > DWELL_MAX) begin
            q = DWELL_MAX;
        end
        for (int s = 0; s < SERVO_COUNT; s++) begin
            delta = int'($signed(r.ang[s]));
            if (r.first) begin
                goal_deg[s]  = limit_deg(delta);
                start_deg[s] = goal_deg[s];
            end else begin
                start_deg[s] = int'(held_target[s]);
                goal_deg[s]  = limit_deg(start_deg[s] + delta);
            end
            held_target[s] = t_angle'(goal_deg[s]);
        end
        for (int j = 0; j < SUBSTEPS; j++) begin
            for (int s = 0; s < SERVO_COUNT; s++) begin
                pos = (SUBSTEPS * start_deg[s] + j * (goal_deg[s] - start_deg[s])) / SUBSTEPS;
                sf.pulse[s] = t_pulse'(PULSE_MIN_NS + (pos * PULSE_SPAN_NS) / ANGLE_MAX);
            end
            sf.dwell = t_dwell'(q);
            sf.last  = (j == SUBSTEPS - 1);
            due_q.push_back(sf);
        end
    endfunction

    function void flag(input string what, input int exp_v, input int got_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
        end
    endfunction

    function void check_subframe(input t_subframe got);
        t_subframe want;
        if (due_q.size() == 0) begin
            flag("unexpected subframe, last_subframe", -1, int'(got.last));
            return;
        end
        want = due_q.pop_front();
        for (int s = 0; s < SERVO_COUNT; s++) begin
            if (got.pulse[s] !== want.pulse[s]) begin
                flag($sformatf("pulse_%0d", s + 1), int'(want.pulse[s]), int'(got.pulse[s]));
            end
        end
        if (got.dwell !== want.dwell) begin
            flag("dwell_ms", int'(want.dwell), int'(got.dwell));
        end
        if (got.last !== want.last) begin
            flag("last_subframe", int'(want.last), int'(got.last));
        end
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ROWS   = 320;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic idle_en;
    int   cycle_cnt = 0;

    subframe_scoreboard sb;

    skf_row_if   row_ch ();
    skf_frame_if frame_ch ();

    t_row_item row_seen;
    t_subframe frame_seen;

    servo_keyframe_interpolator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (row_ch),
        .o_frame (frame_ch)
    );

    always #1 i_clk = ~i_clk;

    assign row_seen = {row_ch.first_row,
                       {row_ch.angle_8, row_ch.angle_7, row_ch.angle_6, row_ch.angle_5,
                        row_ch.angle_4, row_ch.angle_3, row_ch.angle_2, row_ch.angle_1},
                       row_ch.row_duration_ms};

    assign frame_seen = {{frame_ch.pulse_8, frame_ch.pulse_7, frame_ch.pulse_6,
                          frame_ch.pulse_5, frame_ch.pulse_4, frame_ch.pulse_3,
                          frame_ch.pulse_2, frame_ch.pulse_1},
                         frame_ch.dwell_ms, frame_ch.last_subframe};

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout with %0d subframes outstanding", sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && row_ch.valid && row_ch.ready) begin
            sb.note_row(row_seen);
        end
        if (i_rst_n && frame_ch.valid && frame_ch.ready) begin
            sb.check_subframe(frame_seen);
        end
    end

    always @(posedge i_clk) begin
        frame_ch.ready <= i_rst_n && (!idle_en || ($urandom_range(99) >= 35));
    end

    function automatic t_row_item row_of(input logic first, input int a1, input int a2,
                                         input int a3, input int a4, input int a5,
                                         input int a6, input int a7, input int a8,
                                         input int dur);
        t_row_item r;
        r.first  = first;
        r.ang[0] = t_delta'(a1);
        r.ang[1] = t_delta'(a2);
        r.ang[2] = t_delta'(a3);
        r.ang[3] = t_delta'(a4);
        r.ang[4] = t_delta'(a5);
        r.ang[5] = t_delta'(a6);
        r.ang[6] = t_delta'(a7);
        r.ang[7] = t_delta'(a8);
        r.dur    = t_dur'(dur);
        return r;
    endfunction

    task automatic drive_row(input t_row_item r);
        if (idle_en && $urandom_range(99) < 35) begin
            row_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        row_ch.valid           <= 1'b1;
        row_ch.first_row       <= r.first;
        row_ch.angle_1         <= r.ang[0];
        row_ch.angle_2         <= r.ang[1];
        row_ch.angle_3         <= r.ang[2];
        row_ch.angle_4         <= r.ang[3];
        row_ch.angle_5         <= r.ang[4];
        row_ch.angle_6         <= r.ang[5];
        row_ch.angle_7         <= r.ang[6];
        row_ch.angle_8         <= r.ang[7];
        row_ch.row_duration_ms <= r.dur;
        @(posedge i_clk);
        while (!row_ch.ready) @(posedge i_clk);
    endtask

    initial begin : stim
        t_row_item r;
        int        n;
        int        seq_len;
        bit        broken;
        sb = new();
        i_rst_n                <= 1'b0;
        idle_en                <= 1'b1;
        row_ch.valid           <= 1'b0;
        row_ch.first_row       <= 1'b0;
        row_ch.angle_1         <= '0;
        row_ch.angle_2         <= '0;
        row_ch.angle_3         <= '0;
        row_ch.angle_4         <= '0;
        row_ch.angle_5         <= '0;
        row_ch.angle_6         <= '0;
        row_ch.angle_7         <= '0;
        row_ch.angle_8         <= '0;
        row_ch.row_duration_ms <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // delta rows straight out of reset apply to all-zero targets
        drive_row(row_of(1'b0, 50, 180, -180, 255, -256, 1, -1, 0, 7));
        drive_row(row_of(1'b0, -20, -1, 0, -255, 255, 179, 180, 2, 65535));
        // absolute and delta rows, with saturation at both ends
        drive_row(row_of(1'b1, 0, 180, -180, 255, -256, 1, 90, 179, 0));
        drive_row(row_of(1'b0, 180, -180, 255, -256, 0, -1, 1, -90, 65535));
        drive_row(row_of(1'b0, -180, 180, -256, 255, -1, 1, 0, 90, 4));
        drive_row(row_of(1'b1, 180, 180, 180, 180, 180, 180, 180, 180, 5));
        drive_row(row_of(1'b0, -1, -2, -3, -4, -5, -6, -7, -179, 9));
        drive_row(row_of(1'b0, 1, 2, 3, 4, 5, 6, 7, 200, 10));
        drive_row(row_of(1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 65534));
        drive_row(row_of(1'b0, 1, 3, 4, 7, 9, 11, 13, 181, 1));
        drive_row(row_of(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 12345));
        drive_row(row_of(1'b1, 90, 45, 135, 1, 179, 60, 120, 30, 32768));
        drive_row(row_of(1'b0, 90, -45, 45, -1, 1, -60, 60, -30, 21845));
        drive_row(row_of(1'b0, -256, 255, -256, 255, -256, 255, -256, 255, 3));
        drive_row(row_of(1'b1, -1, 256, 511, -255, 181, -181, 100, 80, 65535));
        drive_row(row_of(1'b0, 17, -23, 33, -47, 59, -71, 83, -97, 255));

        n = 0;
        while (n < RAND_ROWS) begin
            seq_len = $urandom_range(1, 8);
            broken  = ($urandom_range(9) == 0);
            for (int k = 0; k < seq_len && n < RAND_ROWS; k++) begin
                if ($urandom_range(9) == 0) begin
                    r.first = 1'($urandom);
                    for (int s = 0; s < SERVO_COUNT; s++) begin
                        r.ang[s] = t_delta'($urandom);
                    end
                    r.dur = t_dur'($urandom);
                end else begin
                    r.first = (k == 0) && !broken;
                    for (int s = 0; s < SERVO_COUNT; s++) begin
                        if (r.first) begin
                            r.ang[s] = t_delta'($urandom_range(180));
                        end else begin
                            r.ang[s] = t_delta'(int'($urandom_range(80)) - 40);
                        end
                    end
                    if ($urandom_range(3) == 0) begin
                        r.dur = t_dur'($urandom_range(20));
                    end else begin
                        r.dur = t_dur'($urandom);
                    end
                end
                idle_en <= !(n >= 100 && n < 200);
                drive_row(r);
                n++;
            end
        end
        row_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/skf_pkg.sv
design/skf_if.sv
design/skf_row_stage.sv
design/skf_subframe_stage.sv
design/servo_keyframe_interpolator_core.sv
test/tb_top.sv
